>>> sv/fsct_pkg.sv
// ============================================================================
// fsct_pkg
// Shared types, constants and the CRC-16/XMODEM byte step for the frame
// sequencer and trailer checker.
// ============================================================================
package fsct_pkg;

    // Largest number of bytes held in one received frame.
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int PLEN_W          = 12;
    localparam int SEQ_BYTES       = 4;
    localparam int CHECK_BYTES     = 2;
    localparam int TAIL_DEPTH      = SEQ_BYTES + CHECK_BYTES;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(TAIL_DEPTH);
    localparam logic [15:0]      CRC_POLY = 16'h1021;

    // Result status codes.
    localparam logic [2:0] ST_TX    = 3'd0;
    localparam logic [2:0] ST_OK    = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_SHORT = 3'd3;
    localparam logic [2:0] ST_CRC   = 3'd4;
    localparam logic [2:0] ST_SEQ   = 3'd5;
    localparam logic [2:0] ST_OVF   = 3'd6;

    // Kinds of result burst handed to the emitter.
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_TRAILER = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // Beat positions within a send trailer burst.
    localparam logic [2:0] BEAT_LEAD   = 3'd0;
    localparam logic [2:0] BEAT_SEQ0   = 3'd1;
    localparam logic [2:0] BEAT_SEQ3   = 3'd4;
    localparam logic [2:0] BEAT_CRC_LO = 3'd5;
    localparam logic [2:0] BEAT_CRC_HI = 3'd6;

    // One burst of results caused by one input item.
    typedef struct packed {
        logic [1:0]        kind;
        logic              lead;
        logic [7:0]        data;
        logic [2:0]        status;
        logic [PLEN_W-1:0] plen;
        logic [15:0]       crc;
        logic [31:0]       seq;
    } burst_t;

    // CRC-16/XMODEM over one byte, MSB first.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> sv/fsct_frame_proc.sv
// ============================================================================
// fsct_frame_proc
// Input register, send CRC and receive frame state, and the decision on
// which burst of results each input item causes.
// ============================================================================
module fsct_frame_proc import fsct_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // Input beat
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         in_op,
    input  logic [7:0]   in_byte,
    input  logic         in_has,
    input  logic         in_last,
    // Configuration write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    // Burst to the emitter
    output logic         burst_valid,
    input  logic         burst_ready,
    output burst_t       burst
);

    // Input register.
    logic        in_valid_reg;
    logic        op_reg;
    logic [7:0]  byte_reg;
    logic        has_reg;
    logic        last_reg;

    // Configuration and frame state.
    logic [31:0]      seq_reg;
    logic [15:0]      send_crc_reg, send_crc_next;
    logic [15:0]      hist_reg [3];
    logic [15:0]      hist_next [3];
    logic [7:0]       tail_reg [TAIL_DEPTH];
    logic [7:0]       tail_next [TAIL_DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;

    logic        produces;
    logic        advance;
    logic [15:0] crc_one;
    logic        take;
    logic        seq_ok;

    assign cfg_ready = 1'b1;

    // An item moves on when it yields nothing or the emitter can take it.
    assign produces    = op_reg ? last_reg : (has_reg | last_reg);
    assign advance     = in_valid_reg & (~produces | burst_ready);
    assign burst_valid = in_valid_reg & produces;
    assign s_ready     = ~in_valid_reg | advance;

    // Next state and the burst descriptor.
    always_comb begin
        crc_one       = crc16_step(op_reg ? hist_reg[0] : send_crc_reg, byte_reg);
        take          = op_reg & has_reg & (cnt_reg < CNT_MAX);
        send_crc_next = send_crc_reg;
        hist_next     = hist_reg;
        tail_next     = tail_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg | (op_reg & has_reg & (cnt_reg >= CNT_MAX));
        seq_ok        = 1'b0;

        burst.kind   = KIND_BYTE;
        burst.lead   = has_reg;
        burst.data   = byte_reg;
        burst.status = ST_TX;
        burst.plen   = '0;
        burst.crc    = has_reg ? crc_one : send_crc_reg;
        burst.seq    = seq_reg;

        if (!op_reg) begin
            // Send: payload byte feeds the CRC; frame end starts a trailer.
            if (has_reg) begin
                send_crc_next = crc_one;
            end
            if (last_reg) begin
                burst.kind    = KIND_TRAILER;
                send_crc_next = '0;
            end
        end else begin
            // Receive: shift the byte into the tail and CRC history.
            if (take) begin
                for (int i = 0; i < TAIL_DEPTH - 1; i++) begin
                    tail_next[i] = tail_reg[i+1];
                end
                tail_next[TAIL_DEPTH-1] = byte_reg;
                hist_next[2] = hist_reg[1];
                hist_next[1] = hist_reg[0];
                hist_next[0] = crc_one;
                cnt_next     = cnt_reg + 1'b1;
            end
            seq_ok = (tail_next[0] == seq_reg[7:0])   && (tail_next[1] == seq_reg[15:8]) &&
                     (tail_next[2] == seq_reg[23:16]) && (tail_next[3] == seq_reg[31:24]);
            burst.kind = KIND_VERDICT;
            burst.data = '0;
            if (ovf_next) begin
                burst.status = ST_OVF;
            end else if (cnt_next == '0) begin
                burst.status = ST_EMPTY;
            end else if (cnt_next < CNT_MIN) begin
                burst.status = ST_SHORT;
            end else if ((tail_next[4] != hist_next[2][7:0]) ||
                         (tail_next[5] != hist_next[2][15:8])) begin
                burst.status = ST_CRC;
            end else if (!seq_ok) begin
                burst.status = ST_SEQ;
            end else begin
                burst.status = ST_OK;
                burst.plen   = PLEN_W'(cnt_next - CNT_MIN);
            end
            // Frame end returns the receive state to reset, tail aside.
            if (last_reg) begin
                hist_next[0] = '0;
                hist_next[1] = '0;
                hist_next[2] = '0;
                cnt_next     = '0;
                ovf_next     = 1'b0;
            end
        end
    end

    // Input register and control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            seq_reg      <= '0;
            send_crc_reg <= '0;
            hist_reg[0]  <= '0;
            hist_reg[1]  <= '0;
            hist_reg[2]  <= '0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                seq_reg <= cfg_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                send_crc_reg <= send_crc_next;
                hist_reg     <= hist_next;
                cnt_reg      <= cnt_next;
                ovf_reg      <= ovf_next;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            op_reg   <= in_op;
            byte_reg <= in_byte;
            has_reg  <= in_has;
            last_reg <= in_last;
        end
        if (advance) begin
            tail_reg <= tail_next;
        end
    end

endmodule

>>> sv/fsct_emitter.sv
// ============================================================================
// fsct_emitter
// Result register that plays out one burst as one or more output beats and
// finishes the trailer CRC over the sequence bytes as they leave.
// ============================================================================
module fsct_emitter import fsct_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // Burst from the frame processor
    input  logic              burst_valid,
    output logic              burst_ready,
    input  burst_t            burst,
    // Result beat
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        out_byte,
    output logic              out_last,
    output logic [2:0]        out_status,
    output logic [PLEN_W-1:0] out_plen
);

    logic              busy_reg;
    logic [2:0]        beat_reg;
    logic [1:0]        kind_reg;
    logic [7:0]        data_reg;
    logic [2:0]        status_reg;
    logic [PLEN_W-1:0] plen_reg;
    logic [15:0]       crc_reg;
    logic [31:0]       seq_reg;

    logic final_beat;
    logic seq_beat;

    assign final_beat  = (kind_reg != KIND_TRAILER) || (beat_reg == BEAT_CRC_HI);
    assign seq_beat    = (beat_reg >= BEAT_SEQ0) && (beat_reg <= BEAT_SEQ3);
    assign burst_ready = ~busy_reg | (m_ready & final_beat);

    // Beat contents.
    assign m_valid    = busy_reg;
    assign out_last   = final_beat;
    assign out_status = status_reg;
    assign out_plen   = plen_reg;

    always_comb begin
        out_byte = data_reg;
        if (kind_reg == KIND_TRAILER) begin
            if (seq_beat) begin
                out_byte = seq_reg[7:0];
            end else if (beat_reg == BEAT_CRC_LO) begin
                out_byte = crc_reg[7:0];
            end else if (beat_reg == BEAT_CRC_HI) begin
                out_byte = crc_reg[15:8];
            end
        end
    end

    // Burst control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (burst_valid && burst_ready) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && m_ready && final_beat) begin
            busy_reg <= 1'b0;
        end
    end

    // Beat position, trailer CRC and the held burst fields.
    always_ff @(posedge aclk) begin
        if (burst_valid && burst_ready) begin
            beat_reg   <= burst.lead ? BEAT_LEAD : BEAT_SEQ0;
            kind_reg   <= burst.kind;
            data_reg   <= burst.data;
            status_reg <= burst.status;
            plen_reg   <= burst.plen;
            crc_reg    <= burst.crc;
            seq_reg    <= burst.seq;
        end else if (busy_reg && m_ready && !final_beat) begin
            beat_reg <= beat_reg + 1'b1;
            if (seq_beat) begin
                crc_reg <= crc16_step(crc_reg, seq_reg[7:0]);
                seq_reg <= {8'h00, seq_reg[31:8]};
            end
        end
    end

endmodule

>>> sv/frame_seq_crc16_trailer_unit.sv
// ============================================================================
// frame_seq_crc16_trailer_unit
// Send-side framer appending sequence number and CRC-16/XMODEM, and
// receive-side frame checker giving one verdict per frame.
// ============================================================================
// Each item is held in the input register, and the results it causes in the result register.
// Throughput: one input beat per cycle while the result stream takes beats; a send
// frame end plays out a trailer of six or seven result beats, during which the next
// item that has results waits in the input register and holds the input.
// Reset: synchronous active-low aresetn clears the sequence register, the
// send CRC and the receive count, CRC history and overflow flag.
module frame_seq_crc16_trailer_unit import fsct_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [1:0]   s_tuser,   // [0] op, [1] has_byte
    input  logic         s_tlast,
    // Configuration write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // [7:0] out_byte, [19:8] payload_length, [23:20] zero
    output logic [2:0]   m_tuser,   // [2:0] status
    output logic         m_tlast
);

    logic              burst_valid;
    logic              burst_ready;
    burst_t            burst;
    logic [7:0]        out_byte;
    logic [PLEN_W-1:0] out_plen;

    fsct_frame_proc u_proc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .in_op       (s_tuser[0]),
        .in_byte     (s_tdata),
        .in_has      (s_tuser[1]),
        .in_last     (s_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst)
    );

    fsct_emitter u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .out_byte    (out_byte),
        .out_last    (m_tlast),
        .out_status  (m_tuser),
        .out_plen    (out_plen)
    );

    // Result beat packing.
    assign m_tdata = {4'h0, out_plen, out_byte};

endmodule

>>> tb/tb_frame_seq_crc16_trailer_unit.sv
// ----------------------------------------------------------------------------
// tb_frame_seq_crc16_trailer_unit
// Self-checking bench for the frame sequencer and CRC-16/XMODEM trailer unit.
// Send frames and received responses are built, interleaved and streamed in
// with random pacing. A scoreboard predicts every result beat, including
// trailers and verdicts, and checks them in order against the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frame_seq_crc16_trailer_unit;
    import fsct_pkg::*;

    localparam bit OP_SEND = 1'b0;
    localparam bit OP_RECV = 1'b1;

    // Shapes of received frame that the stimulus builds.
    typedef enum int {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_SEQ,
        FR_SHORT,
        FR_EMPTY,
        FR_JUNK
    } frame_kind_t;

    // One input beat: op, data byte, byte-present flag and frame end.
    typedef struct packed {
        bit       op;
        bit [7:0] data;
        bit       has;
        bit       last;
    } item_t;

    // One predicted result beat.
    typedef struct packed {
        logic [7:0]        out_byte;
        logic              out_last;
        logic [2:0]        status;
        logic [PLEN_W-1:0] plen;
    } result_t;

    // Scoreboard: mirrors the send and receive state and holds the result
    // beats still owed by the block, oldest first.
    class frame_scoreboard_t;
        bit [31:0]   seq_reg;
        bit [15:0]   tx_crc;
        bit [15:0]   rx_crc_hist [3];
        bit [7:0]    rx_tail [TAIL_DEPTH];
        int unsigned rx_count;
        bit          rx_overflow;
        result_t     owed_q [$];
        int unsigned errors;
        int unsigned inputs_noted;
        int unsigned results_checked;
        int unsigned status_seen [8];

        function new();
            seq_reg = '0;
            tx_crc  = '0;
            errors  = 0;
            inputs_noted    = 0;
            results_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            foreach (rx_tail[i]) rx_tail[i] = '0;
            clear_rx();
        endfunction

        // CRC-16/XMODEM, one byte, most significant bit first.
        static function bit [15:0] crc_byte(bit [15:0] crc, bit [7:0] b);
            bit [15:0] c;
            c = crc ^ {b, 8'h00};
            for (int k = 0; k < 8; k++) begin
                if (c[15]) c = (c << 1) ^ 16'h1021;
                else       c = c << 1;
            end
            return c;
        endfunction

        function void clear_rx();
            foreach (rx_crc_hist[i]) rx_crc_hist[i] = '0;
            rx_count    = 0;
            rx_overflow = 1'b0;
        endfunction

        function void owe(bit [7:0] b, bit l, bit [2:0] st, bit [PLEN_W-1:0] pl);
            result_t r;
            r.out_byte = b;
            r.out_last = l;
            r.status   = st;
            r.plen     = pl;
            owed_q.push_back(r);
        endfunction

        // Work out the result beats caused by one accepted input beat.
        function void note_input(bit op, bit [7:0] b, bit has, bit last);
            bit [2:0]          st;
            bit [PLEN_W-1:0]   pl;
            bit [15:0]         c;
            inputs_noted++;
            if (op == OP_SEND) begin
                if (has) begin
                    tx_crc = crc_byte(tx_crc, b);
                    owe(b, !last, ST_TX, '0);
                end
                if (last) begin
                    for (int i = 0; i < SEQ_BYTES; i++) begin
                        tx_crc = crc_byte(tx_crc, seq_reg[8*i +: 8]);
                        owe(seq_reg[8*i +: 8], 1'b0, ST_TX, '0);
                    end
                    owe(tx_crc[7:0], 1'b0, ST_TX, '0);
                    owe(tx_crc[15:8], 1'b1, ST_TX, '0);
                    tx_crc = '0;
                end
                return;
            end
            // Receive side: bytes beyond capacity are dropped and flagged.
            if (has) begin
                if (rx_count >= MAX_FRAME_BYTES) begin
                    rx_overflow = 1'b1;
                end else begin
                    for (int i = 0; i < TAIL_DEPTH - 1; i++) rx_tail[i] = rx_tail[i+1];
                    rx_tail[TAIL_DEPTH-1] = b;
                    rx_crc_hist[2] = rx_crc_hist[1];
                    rx_crc_hist[1] = rx_crc_hist[0];
                    rx_crc_hist[0] = crc_byte(rx_crc_hist[0], b);
                    rx_count++;
                end
            end
            if (!last) return;
            pl = '0;
            c  = rx_crc_hist[2];
            if (rx_overflow) begin
                st = ST_OVF;
            end else if (rx_count == 0) begin
                st = ST_EMPTY;
            end else if (rx_count < TAIL_DEPTH) begin
                st = ST_SHORT;
            end else if (rx_tail[4] != c[7:0] || rx_tail[5] != c[15:8]) begin
                st = ST_CRC;
            end else begin
                st = ST_OK;
                for (int i = 0; i < SEQ_BYTES; i++)
                    if (rx_tail[i] != seq_reg[8*i +: 8]) st = ST_SEQ;
                if (st == ST_OK) pl = PLEN_W'(rx_count - TAIL_DEPTH);
            end
            owe(8'h00, 1'b1, st, pl);
            clear_rx();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // Compare one accepted result beat with the oldest owed beat.
        task check_result(logic [7:0] ob, logic ol, logic [2:0] st,
                          logic [PLEN_W-1:0] pl, logic [3:0] pad);
            result_t e;
            results_checked++;
            if (st <= ST_OVF) status_seen[st]++;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected result beat byte=%02h status=%0d", ob, st));
                return;
            end
            e = owed_q.pop_front();
            if (ob !== e.out_byte)
                report($sformatf("out_byte %02h, expected %02h", ob, e.out_byte));
            if (ol !== e.out_last)
                report($sformatf("out_last %0b, expected %0b", ol, e.out_last));
            if (st !== e.status)
                report($sformatf("status %0d, expected %0d", st, e.status));
            if (pl !== e.plen)
                report($sformatf("payload_length %0d, expected %0d", pl, e.plen));
            if (pad !== 4'h0)
                report($sformatf("tdata padding %h is not zero", pad));
        endtask
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        s_tlast   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    frame_scoreboard_t book;
    item_t       rx_items [$];
    item_t       tx_items [$];
    bit          tx_eager = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned n_settings = 0;

    frame_seq_crc16_trailer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one input beat after a random gap and wait for it to be taken.
    // Valid is left high so that a back-to-back beat needs no extra edge.
    task automatic put_item(bit op, bit [7:0] b, bit has, bit last);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {has, op};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_input(op, b, has, last);
    endtask

    // Drain the two frame queues, picking between them at random.
    task automatic play_items();
        item_t it;
        bit    take_rx;
        while (rx_items.size() != 0 || tx_items.size() != 0) begin
            if (rx_items.size() == 0)      take_rx = 1'b0;
            else if (tx_items.size() == 0) take_rx = 1'b1;
            else                           take_rx = 1'($urandom_range(0, 1));
            it = take_rx ? rx_items.pop_front() : tx_items.pop_front();
            put_item(it.op, it.data, it.has, it.last);
        end
    endtask

    // Build one received frame of the given shape; n is the payload length,
    // or the whole length for junk frames; short frames get a random length.
    function automatic void build_rx(frame_kind_t kind, int n, bit end_on_byte,
                                     bit with_noise);
        bit [7:0]  bytes [$];
        bit [15:0] c;
        item_t     it;
        int        idx;
        c = '0;
        case (kind)
            FR_EMPTY: ;
            FR_SHORT: begin
                repeat ($urandom_range(1, TAIL_DEPTH - 1)) bytes.push_back(8'($urandom));
            end
            FR_JUNK: begin
                repeat (n) bytes.push_back(8'($urandom));
            end
            default: begin
                repeat (n) bytes.push_back(8'($urandom));
                for (int i = 0; i < SEQ_BYTES; i++) bytes.push_back(book.seq_reg[8*i +: 8]);
                if (kind == FR_BAD_SEQ) begin
                    idx = n + $urandom_range(0, SEQ_BYTES - 1);
                    bytes[idx] = bytes[idx] ^ 8'($urandom_range(1, 255));
                end
                foreach (bytes[i]) c = frame_scoreboard_t::crc_byte(c, bytes[i]);
                if (kind == FR_BAD_CRC) c = c ^ 16'($urandom_range(1, 65535));
                bytes.push_back(c[7:0]);
                bytes.push_back(c[15:8]);
            end
        endcase
        foreach (bytes[i]) begin
            if (with_noise && $urandom_range(0, 7) == 0)
                rx_items.push_back(item_t'{OP_RECV, 8'($urandom), 1'b0, 1'b0});
            rx_items.push_back(item_t'{OP_RECV, bytes[i], 1'b1, 1'b0});
        end
        // Close either on the final byte or with a byte-less end beat.
        if (bytes.size() != 0 && end_on_byte) begin
            it = rx_items.pop_back();
            it.last = 1'b1;
            rx_items.push_back(it);
        end else begin
            rx_items.push_back(item_t'{OP_RECV, 8'($urandom), 1'b0, 1'b1});
        end
    endfunction

    // Build one send frame of n payload bytes.
    function automatic void build_tx(int n);
        item_t it;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0)
                tx_items.push_back(item_t'{OP_SEND, 8'($urandom), 1'b0, 1'b0});
            tx_items.push_back(item_t'{OP_SEND, 8'($urandom), 1'b1, 1'b0});
        end
        if (n > 0 && $urandom_range(0, 1) == 1) begin
            it = tx_items.pop_back();
            it.last = 1'b1;
            tx_items.push_back(it);
        end else begin
            tx_items.push_back(item_t'{OP_SEND, 8'($urandom), 1'b0, 1'b1});
        end
    endfunction

    // Stop offering input and let every owed result and in-flight beat clear.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (book.owed_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_seq(bit [31:0] v);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        book.seq_reg = v;
        n_settings++;
    endtask

    // Random responses, half of them well-formed, often interleaved with a send frame.
    task automatic random_traffic(int unsigned n_items);
        int unsigned start;
        int          roll;
        frame_kind_t kind;
        int          n;
        start = book.inputs_noted;
        while (book.inputs_noted - start < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 50)      kind = FR_GOOD;
            else if (roll < 62) kind = FR_BAD_CRC;
            else if (roll < 74) kind = FR_BAD_SEQ;
            else if (roll < 84) kind = FR_SHORT;
            else if (roll < 90) kind = FR_EMPTY;
            else                kind = FR_JUNK;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
            if (kind == FR_JUNK) n = n + TAIL_DEPTH;
            build_rx(kind, n, 1'($urandom_range(0, 1)), 1'b1);
            if ($urandom_range(0, 9) < 6) build_tx($urandom_range(0, 12));
            tx_eager = ($urandom_range(0, 3) == 0);
            play_items();
        end
    endtask

    // Result side: random ready pacing, with one long hold-off to back the
    // block up into its input.
    initial begin
        int gap;
        bit held;
        bit eager;
        held  = 1'b0;
        eager = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) eager = !eager;
            if (!held && hold_req) begin
                gap  = 400;
                held = 1'b1;
            end else begin
                gap = eager ? 0 : $urandom_range(0, 10);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            book.check_result(m_tdata[7:0], m_tlast, m_tuser, m_tdata[19:8],
                              m_tdata[23:20]);
        end
    end

    // Main sequence.
    initial begin
        book = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: idle beats, byte extremes, trailer-only send, and each
        // receive verdict that a short frame can reach.
        put_item(OP_SEND, 8'h5a, 1'b0, 1'b0);
        put_item(OP_RECV, 8'hc3, 1'b0, 1'b0);
        put_item(OP_SEND, 8'h00, 1'b1, 1'b0);
        put_item(OP_SEND, 8'hff, 1'b1, 1'b1);
        put_item(OP_SEND, 8'h81, 1'b0, 1'b1);
        put_item(OP_RECV, 8'h00, 1'b0, 1'b1);
        put_item(OP_RECV, 8'hff, 1'b1, 1'b1);
        build_rx(FR_GOOD, 0, 1'b1, 1'b0);
        build_rx(FR_BAD_CRC, 0, 1'b1, 1'b0);
        build_rx(FR_BAD_SEQ, 0, 1'b0, 1'b0);
        play_items();

        // Send frames keep coming while the result side holds off for long.
        hold_req = 1'b1;
        repeat (3) build_tx($urandom_range(4, 10));
        play_items();

        // All-ones and all-zeros sequences, then two random ones.
        write_seq(32'hffff_ffff);
        random_traffic(25);
        write_seq(32'h0000_0000);
        random_traffic(25);
        write_seq($urandom);
        random_traffic(25);
        write_seq($urandom);
        random_traffic(25);

        quiesce();
        repeat (20) @(posedge aclk);
        if (book.owed_q.size() != 0)
            book.report($sformatf("%0d result beats never arrived", book.owed_q.size()));

        $display("Run covered %0d input beats, %0d result beats, %0d sequence settings.",
                 book.inputs_noted, book.results_checked, n_settings);
        $display("Verdicts: ok %0d, empty %0d, short %0d, crc %0d, seq %0d, overflow %0d.",
                 book.status_seen[ST_OK], book.status_seen[ST_EMPTY],
                 book.status_seen[ST_SHORT], book.status_seen[ST_CRC],
                 book.status_seen[ST_SEQ], book.status_seen[ST_OVF]);
        if (book.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
